/* sv/http_chunked_body_decoder_top_macros.svh */
// Assertion macros shared by the decoder's checker.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef HTTP_CHUNKED_BODY_DECODER_TOP_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HCBD_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("hcbd: same-cycle implication violated");

// Next-cycle implication, disabled during reset.
`define HCBD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("hcbd: next-cycle implication violated");

`endif

/* sv/hcbd_pkg.sv */
// Types, constants and helpers for the chunked body decoder.
// Used by hcbd_step, hcbd_obuf and the top level; depends on nothing.
package hcbd_pkg;

    typedef enum logic [2:0] {
        PH_DIGITS   = 3'd0,
        PH_LINEREST = 3'd1,
        PH_DATA     = 3'd2,
        PH_TRAIL    = 3'd3,
        PH_DONE     = 3'd4,
        PH_ERROR    = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        REG_CHUNKED_MODE    = 2'd0,
        REG_DECLARED_LENGTH = 2'd1,
        REG_MAX_BODY_SIZE   = 2'd2
    } reg_index_t;

    localparam int unsigned LEN_W   = 40;
    localparam int unsigned TOTAL_W = 41;
    localparam int unsigned REM_W   = 64;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    localparam logic [LEN_W-1:0] MAX_BODY_RESET = 40'd1048576;

    typedef struct packed {
        phase_t             phase;
        logic [REM_W-1:0]   remaining;
        logic [TOTAL_W-1:0] total;
        logic               prior_cr;
    } state_t;

    typedef struct packed {
        logic               chunked_mode;
        logic [LEN_W-1:0]   declared_length;
        logic [LEN_W-1:0]   max_body_size;
    } cfg_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       body_done;
        logic       status_code;
    } result_t;

    // Returns {is_hex, value}.
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39)
            r = {1'b1, 4'(b - 8'h30)};
        else if (b >= 8'h61 && b <= 8'h66)
            r = {1'b1, 4'(b - 8'h57)};
        else if (b >= 8'h41 && b <= 8'h46)
            r = {1'b1, 4'(b - 8'h37)};
        return r;
    endfunction

endpackage

/* sv/hcbd_step.sv */
// Next-state and result logic for one body byte of the chunked decoder.
// Purely combinational; depends on hcbd_pkg.
module hcbd_step
(
    input  hcbd_pkg::state_t  cur,
    input  hcbd_pkg::cfg_t    cfg,
    input  logic [7:0]        data_byte,
    output hcbd_pkg::state_t  nxt,
    output hcbd_pkg::result_t res
);

    logic [hcbd_pkg::TOTAL_W-1:0] total_inc;
    logic                         over_limit;
    logic                         len_reached_now;
    logic                         len_reached_inc;
    logic                         rem_zero;
    logic                         rem_one;
    logic [4:0]                   hex;
    logic                         line_end;
    logic                         pass;

    always_comb
    begin
        total_inc       = (&cur.total) ? cur.total : cur.total + 1'b1;
        over_limit      = total_inc > {1'b0, cfg.max_body_size};
        len_reached_now = cur.total >= {1'b0, cfg.declared_length};
        len_reached_inc = total_inc >= {1'b0, cfg.declared_length};
        rem_zero        = (cur.remaining == '0);
        rem_one         = (cur.remaining == hcbd_pkg::REM_W'(1));
        hex             = hcbd_pkg::hex_decode(data_byte);
        line_end        = cur.prior_cr && (data_byte == hcbd_pkg::CHAR_LF);
    end

    always_comb
    begin
        nxt  = cur;
        pass = 1'b0;
        priority if (cur.phase == hcbd_pkg::PH_DONE || cur.phase == hcbd_pkg::PH_ERROR)
        begin
            // sticky end states: drop the byte
        end
        else if (!cfg.chunked_mode)
        begin
            nxt.prior_cr = 1'b0;
            if (len_reached_now)
                nxt.phase = hcbd_pkg::PH_DONE;
            else
            begin
                nxt.total = total_inc;
                if (over_limit)
                    nxt.phase = hcbd_pkg::PH_ERROR;
                else
                begin
                    pass = 1'b1;
                    if (len_reached_inc)
                        nxt.phase = hcbd_pkg::PH_DONE;
                end
            end
        end
        else if (cur.phase == hcbd_pkg::PH_DATA)
        begin
            nxt.prior_cr = 1'b0;
            if (rem_zero)
                nxt.phase = hcbd_pkg::PH_TRAIL;
            else
            begin
                nxt.total = total_inc;
                if (over_limit)
                    nxt.phase = hcbd_pkg::PH_ERROR;
                else
                begin
                    pass          = 1'b1;
                    nxt.remaining = cur.remaining - 1'b1;
                    if (rem_one)
                        nxt.phase = hcbd_pkg::PH_TRAIL;
                end
            end
        end
        else
        begin
            // line phases: size digits, rest of size line, skip after data
            nxt.prior_cr = (data_byte == hcbd_pkg::CHAR_CR);
            if (line_end)
            begin
                nxt.prior_cr = 1'b0;
                priority if (cur.phase == hcbd_pkg::PH_TRAIL)
                begin
                    nxt.phase     = hcbd_pkg::PH_DIGITS;
                    nxt.remaining = '0;
                end
                else if (rem_zero)
                    nxt.phase = hcbd_pkg::PH_DONE;
                else
                    nxt.phase = hcbd_pkg::PH_DATA;
            end
            else if (cur.phase == hcbd_pkg::PH_DIGITS)
            begin
                priority if (!hex[4])
                    nxt.phase = hcbd_pkg::PH_LINEREST;
                else if (cur.remaining[hcbd_pkg::REM_W-1 -: 4] != 4'd0)
                    nxt.remaining = '1;
                else
                    nxt.remaining = {cur.remaining[hcbd_pkg::REM_W-5:0], hex[3:0]};
            end
        end
    end

    always_comb
    begin
        res.payload_byte  = pass ? data_byte : 8'd0;
        res.payload_valid = pass;
        res.body_done     = (nxt.phase == hcbd_pkg::PH_DONE);
        res.status_code   = (nxt.phase == hcbd_pkg::PH_ERROR);
    end

endmodule

/* sv/hcbd_obuf.sv */
// Two-entry result buffer between the decode logic and the output channel.
// Stall towards the input comes from a register only; depends on hcbd_pkg.
module hcbd_obuf
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  hcbd_pkg::result_t din,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output hcbd_pkg::result_t dout
);

    hcbd_pkg::result_t slot0_reg, slot0_next;
    hcbd_pkg::result_t slot1_reg, slot1_next;
    logic [1:0]        count_reg, count_next;
    logic              pop;

    assign out_valid = (count_reg != 2'd0);
    assign full      = count_reg[1];
    assign dout      = slot0_reg;
    assign pop       = out_valid && !out_stall;

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        unique case ({push, pop})
            2'b10:
            begin
                if (count_reg == 2'd0)
                    slot0_next = din;
                else
                    slot1_next = din;
                count_next = count_reg + 2'd1;
            end
            2'b01:
            begin
                slot0_next = slot1_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11:
            begin
                // advance the head and refill behind it
                if (count_reg == 2'd1)
                    slot0_next = din;
                else
                begin
                    slot0_next = slot1_reg;
                    slot1_next = din;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

/* sv/http_chunked_body_decoder_top.sv */
// Top level of the HTTP/1.1 chunked body decoder: config registers, decode state.
// Depends on hcbd_pkg, hcbd_step and hcbd_obuf.
//
//  channel | signals                                  | handshake
//  --------+------------------------------------------+-------------------------
//  in      | data_byte                                | in_valid, in_stall
//  out     | payload_byte, payload_valid, body_done,  | out_valid, out_stall
//          | status_code                              |
//  cfg     | cfg_index, cfg_data                      | cfg_valid, cfg_ready
//
// One item per clock while in_stall is low: each byte is decoded in the cycle it
// is accepted, with its result landing in a two-entry output buffer on the same edge.
// Results reach the outputs from the buffer registers, not straight from the input.
// in_stall rises only when both buffer entries hold untaken results.
// Reset clears the decode state to the first size line and loads the
// configuration defaults (length mode, zero length, 1 MiB limit).
module http_chunked_body_decoder_top
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  payload_byte,
    output logic        payload_valid,
    output logic        body_done,
    output logic        status_code,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [39:0] cfg_data
);

    hcbd_pkg::cfg_t    cfg_reg, cfg_next;
    hcbd_pkg::state_t  state_reg, state_next;
    hcbd_pkg::state_t  step_state;
    hcbd_pkg::result_t step_res;
    hcbd_pkg::result_t buf_out;
    logic              buf_full;
    logic              accept;

    // Configuration is always writable; write it only while no item is in flight.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                hcbd_pkg::REG_CHUNKED_MODE:    cfg_next.chunked_mode    = cfg_data[0];
                hcbd_pkg::REG_DECLARED_LENGTH: cfg_next.declared_length = cfg_data;
                hcbd_pkg::REG_MAX_BODY_SIZE:   cfg_next.max_body_size   = cfg_data;
                default:
                begin
                    // unused index: drop the write
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.chunked_mode    <= 1'b0;
            cfg_reg.declared_length <= '0;
            cfg_reg.max_body_size   <= hcbd_pkg::MAX_BODY_RESET;
        end
        else
            cfg_reg <= cfg_next;
    end

    // Decode the incoming byte against the current state.
    hcbd_step u_step
    (
        .cur       (state_reg),
        .cfg       (cfg_reg),
        .data_byte (data_byte),
        .nxt       (step_state),
        .res       (step_res)
    );

    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    // Advance the decode state only on an accepted item; hold otherwise.
    assign state_next = accept ? step_state : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase     <= hcbd_pkg::PH_DIGITS;
            state_reg.remaining <= '0;
            state_reg.total     <= '0;
            state_reg.prior_cr  <= 1'b0;
        end
        else
            state_reg <= state_next;
    end

    // Results queue here so that a stalled consumer does not block the input until both entries are full.
    hcbd_obuf u_obuf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .din       (step_res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dout      (buf_out)
    );

    assign payload_byte  = buf_out.payload_byte;
    assign payload_valid = buf_out.payload_valid;
    assign body_done     = buf_out.body_done;
    assign status_code   = buf_out.status_code;

endmodule

/* sv/hcbd_checker.sv */
// Port-level checker for the chunked body decoder, bound to the top level.
// Depends on http_chunked_body_decoder_top_macros.svh.
`include "http_chunked_body_decoder_top_macros.svh"

module hcbd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] payload_byte,
    input logic       payload_valid,
    input logic       body_done,
    input logic       status_code
);

    `HCBD_ASSERT_SAME(a_done_err_excl, clk, rst_n, out_valid, !(body_done && status_code))
    `HCBD_ASSERT_SAME(a_no_payload_in_err, clk, rst_n, out_valid && payload_valid, !status_code)
    `HCBD_ASSERT_SAME(a_idle_byte_zero, clk, rst_n, out_valid && !payload_valid, payload_byte == 8'd0)
    `HCBD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

endmodule

bind http_chunked_body_decoder_top hcbd_checker u_hcbd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .payload_byte  (payload_byte),
    .payload_valid (payload_valid),
    .body_done     (body_done),
    .status_code   (status_code)
);

/* test/tb_http_chunked_body_decoder_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for http_chunked_body_decoder_top: a directed table of chunked
// bytes, then random chunked bodies with mode and limit changes, all scored in order.
// Depends on hcbd_pkg and the decoder RTL; needs no files or arguments.
module tb_http_chunked_body_decoder_top;
    import hcbd_pkg::*;

    // Random stimulus stops once this many items have been accepted.
    localparam int unsigned RANDOM_ITEMS = 1420;
    localparam logic [39:0] LEN_ALL_ONES = '1;
    localparam logic [7:0]  LOWER_A      = "a";
    localparam logic [7:0]  UPPER_A      = "A";

    typedef struct {
        logic [7:0] b;
        bit         typed;
        result_t    want;
    } dir_row_t;

    // Every input starts at a known value.
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  data_byte = 8'h00;
    logic        out_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [39:0] cfg_data  = 40'd0;
    logic        in_stall;
    logic        out_valid;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        body_done;
    logic        status_code;
    logic        cfg_ready;

    // Decoder model: its own copy of the registers and the decode state.
    logic               mode_chunked = 1'b0;
    logic [LEN_W-1:0]   body_len     = '0;
    logic [LEN_W-1:0]   body_limit   = MAX_BODY_RESET;
    phase_t             ph           = PH_DIGITS;
    logic [REM_W-1:0]   chunk_left   = '0;
    logic [TOTAL_W-1:0] passed_total = '0;
    logic               last_cr      = 1'b0;

    result_t     expected_q [$];
    logic [7:0]  chunk_bytes [$];
    dir_row_t    dir_rows [$];
    int unsigned items_sent  = 0;
    int unsigned burst_left  = 0;
    int unsigned mismatches  = 0;
    int unsigned stall_left  = 0;
    int unsigned stall_style = 0;
    result_t     oldest;

    http_chunked_body_decoder_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .payload_byte  (payload_byte),
        .payload_valid (payload_valid),
        .body_done     (body_done),
        .status_code   (status_code),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // Hold the run to a generous ceiling; a hang ends here.
    initial
    begin
        #2_000_000;
        $display("http_chunked_body_decoder_top test failed");
        $finish;
    end

    // -------------------------------------------------------------------------
    // Decoder model
    // -------------------------------------------------------------------------

    function automatic int hex_val(input logic [7:0] b);
        if (b >= "0" && b <= "9")
            return int'(b - "0");
        if (b >= "a" && b <= "f")
            return int'(b - "a") + 10;
        if (b >= "A" && b <= "F")
            return int'(b - "A") + 10;
        return -1;
    endfunction

    // Count one payload byte against the limit; the total saturates at 41 bits.
    function automatic bit take_payload();
        if (passed_total != '1)
            passed_total = passed_total + 1'b1;
        if (passed_total > {1'b0, body_limit})
        begin
            ph = PH_ERROR;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic result_t decode_step(input logic [7:0] b);
        bit      passes;
        bit      line_end;
        int      nib;
        result_t r;
        passes = 1'b0;
        // Done and error are sticky: ignore the byte and hold the flags.
        if (ph != PH_DONE && ph != PH_ERROR)
        begin
            if (!mode_chunked)
            begin
                last_cr = 1'b0;
                if (passed_total >= {1'b0, body_len})
                    ph = PH_DONE;
                else if (take_payload())
                begin
                    passes = 1'b1;
                    if (passed_total >= {1'b0, body_len})
                        ph = PH_DONE;
                end
            end
            else if (ph == PH_DATA)
            begin
                last_cr = 1'b0;
                if (chunk_left == 0)
                    ph = PH_TRAIL;
                else if (take_payload())
                begin
                    passes     = 1'b1;
                    chunk_left = chunk_left - 1'b1;
                    if (chunk_left == 0)
                        ph = PH_TRAIL;
                end
            end
            else
            begin
                line_end = last_cr && b == CHAR_LF;
                last_cr  = (b == CHAR_CR);
                if (line_end)
                begin
                    last_cr = 1'b0;
                    if (ph == PH_TRAIL)
                    begin
                        ph         = PH_DIGITS;
                        chunk_left = '0;
                    end
                    else if (chunk_left == 0)
                        ph = PH_DONE;
                    else
                        ph = PH_DATA;
                end
                else if (ph == PH_DIGITS)
                begin
                    nib = hex_val(b);
                    if (nib < 0)
                        ph = PH_LINEREST;
                    else if (chunk_left > {4'h0, {(REM_W-4){1'b1}}})
                        chunk_left = '1;
                    else
                        chunk_left = {chunk_left[REM_W-5:0], 4'(nib)};
                end
            end
        end
        r.payload_byte  = passes ? b : 8'h00;
        r.payload_valid = passes;
        r.body_done     = (ph == PH_DONE);
        r.status_code   = (ph == PH_ERROR);
        return r;
    endfunction

    // -------------------------------------------------------------------------
    // Byte generators
    // -------------------------------------------------------------------------

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
            return "0" + 8'(nib);
        return (($urandom_range(0, 1) != 0) ? LOWER_A : UPPER_A) + 8'(nib - 4'd10);
    endfunction

    function automatic logic [7:0] rand_other(input logic [7:0] excluded);
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (b == excluded);
        return b;
    endfunction

    // A byte that ends the digit run without starting a line end.
    function automatic logic [7:0] rand_nonhex();
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (hex_val(b) >= 0 || b == CHAR_CR);
        return b;
    endfunction

    function automatic dir_row_t drow(input logic [7:0] b, input bit typed, input bit passes);
        dir_row_t row;
        row.b                  = b;
        row.typed              = typed;
        row.want.payload_byte  = passes ? b : 8'h00;
        row.want.payload_valid = passes;
        row.want.body_done     = 1'b0;
        row.want.status_code   = 1'b0;
        return row;
    endfunction

    // Optional extension (junk after the digits, hex included), then CR LF.
    task automatic add_line_end();
        if ($urandom_range(0, 3) == 0)
        begin
            chunk_bytes.push_back(rand_nonhex());
            repeat ($urandom_range(0, 6)) chunk_bytes.push_back(rand_other(CHAR_CR));
        end
        chunk_bytes.push_back(CHAR_CR);
        chunk_bytes.push_back(CHAR_LF);
    endtask

    task automatic add_size_line(input logic [31:0] n, input int unsigned zeros);
        bit started;
        started = 1'b0;
        repeat (zeros) chunk_bytes.push_back("0");
        for (int s = 28; s >= 0; s -= 4)
        begin
            if (started || n[s +: 4] != 4'd0 || s == 0)
            begin
                chunk_bytes.push_back(hex_char(n[s +: 4]));
                started = 1'b1;
            end
        end
        add_line_end();
    endtask

    // One well-formed chunk, sometimes with junk before the closing CR LF.
    task automatic build_chunk();
        int unsigned n;
        int unsigned pick;
        chunk_bytes.delete();
        pick = $urandom_range(0, 19);
        if (pick < 14)
            n = $urandom_range(1, 16);
        else if (pick < 19)
            n = $urandom_range(17, 64);
        else
            n = $urandom_range(65, 300);
        add_size_line(n, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
        repeat (n) chunk_bytes.push_back(8'($urandom));
        // Junk without LF stays in the skip phase; CRs in it stand alone.
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 5)) chunk_bytes.push_back(rand_other(CHAR_LF));
        chunk_bytes.push_back(CHAR_CR);
        chunk_bytes.push_back(CHAR_LF);
    endtask

    // -------------------------------------------------------------------------
    // Channel drivers
    // -------------------------------------------------------------------------

    // Offer one item; the model is stepped when the item is accepted.
    // Each call starts in the step of the previous acceptance, so valid is
    // raised once and never lowered and raised again at the same edge.
    task automatic push_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input result_t want = '0);
        int unsigned gap;
        result_t     predicted;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        data_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        predicted = decode_step(b);
        expected_q.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic send_range(input int unsigned lo, input int unsigned hi);
        for (int unsigned i = lo; i < hi; i++)
            push_byte(chunk_bytes[i]);
    endtask

    // Drop valid and wait for every expected result, then a few spare cycles.
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic cfg_write(input reg_index_t idx, input logic [39:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_CHUNKED_MODE:    mode_chunked = value[0];
            REG_DECLARED_LENGTH: body_len     = value;
            REG_MAX_BODY_SIZE:   body_limit   = value;
            default:
            begin
            end
        endcase
    endtask

    // Switch to length mode for a short run of bytes, with plenty of length
    // left so the body does not end, then return to chunked decoding.
    task automatic length_mode_run();
        settle();
        cfg_write(REG_CHUNKED_MODE, 40'd0);
        cfg_write(REG_DECLARED_LENGTH, ($urandom_range(0, 1) != 0) ? LEN_ALL_ONES
                  : 40'(passed_total) + 40'd600 + 40'($urandom_range(0, 1000)));
        repeat ($urandom_range(1, 30)) push_byte(8'($urandom));
        settle();
        cfg_write(REG_CHUNKED_MODE, 40'd1);
    endtask

    // Move the size limit, always well above what the rest of the run passes.
    task automatic move_limit();
        settle();
        cfg_write(REG_MAX_BODY_SIZE, ($urandom_range(0, 1) != 0) ? LEN_ALL_ONES
                  : 40'(passed_total) + 40'd4096 + 40'($urandom));
    endtask

    // End the body one of several ways, then check that later bytes are ignored.
    task automatic close_body();
        int unsigned pick;
        pick = $urandom_range(0, 5);
        chunk_bytes.delete();
        if (pick == 0)
            add_size_line(32'd0, $urandom_range(0, 2));
        else if (pick == 1)
            add_line_end();
        else
        begin
            // Too many digits: the size saturates and the chunk never runs out.
            chunk_bytes.push_back(hex_char(4'hF));
            repeat ($urandom_range(16, 20)) chunk_bytes.push_back(hex_char(4'($urandom)));
            add_line_end();
            repeat ($urandom_range(1, 20)) chunk_bytes.push_back(8'($urandom));
        end
        send_range(0, chunk_bytes.size());
        settle();
        case (pick)
            2:
            begin
                cfg_write(REG_CHUNKED_MODE, 40'd0);
                cfg_write(REG_DECLARED_LENGTH, 40'(passed_total) + 40'($urandom_range(0, 5)));
            end
            3:
            begin
                cfg_write(REG_CHUNKED_MODE, 40'd0);
                cfg_write(REG_DECLARED_LENGTH, 40'd0);
            end
            4:
                cfg_write(REG_MAX_BODY_SIZE, ($urandom_range(0, 2) == 0) ? 40'd0
                          : 40'(passed_total) + 40'($urandom_range(0, 5)));
            5:
            begin
                cfg_write(REG_CHUNKED_MODE, 40'd0);
                cfg_write(REG_DECLARED_LENGTH, LEN_ALL_ONES);
                cfg_write(REG_MAX_BODY_SIZE, 40'(passed_total) + 40'($urandom_range(0, 5)));
            end
            default:
            begin
                // the body already ended on its own line
            end
        endcase
        repeat (12) push_byte(8'($urandom));
    endtask

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // -------------------------------------------------------------------------
    // Result side: score each accepted result against the oldest expectation,
    // and drive out_stall from a pattern that switches at random among four
    // styles (free flow, light stalls, heavy stalls, a square wave).
    // -------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: result with nothing expected, expected none, actual %0h %0b %0b %0b",
                         $time, payload_byte, payload_valid, body_done, status_code);
                mismatches++;
            end
            else
            begin
                oldest = expected_q.pop_front();
                check_field("payload_byte", oldest.payload_byte, payload_byte);
                check_field("payload_valid", 8'(oldest.payload_valid), 8'(payload_valid));
                check_field("body_done", 8'(oldest.body_done), 8'(body_done));
                check_field("status_code", 8'(oldest.status_code), 8'(status_code));
            end
        end
        if (stall_left == 0)
        begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(16, 128);
        end
        else
            stall_left--;
        case (stall_style)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= stall_left[2];
        endcase
    end

    // -------------------------------------------------------------------------
    // Stimulus
    // -------------------------------------------------------------------------
    initial
    begin
        int unsigned split;
        int unsigned roll;
        int unsigned spins;

        // Hold reset from time zero, then release it; it is never asserted again.
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Chunked decoding with the widest limit; the length is unused here.
        cfg_write(REG_CHUNKED_MODE, 40'd1);
        cfg_write(REG_DECLARED_LENGTH, LEN_ALL_ONES);
        cfg_write(REG_MAX_BODY_SIZE, LEN_ALL_ONES);

        // Directed table: a size line with an extension, data at the byte
        // extremes and a CR inside the data, a trailer with a lone CR, a size
        // line with leading zeros, and an LF carried as data.
        dir_rows = '{
            drow("3", 1'b1, 1'b0), drow(";", 1'b1, 1'b0), drow("x", 1'b1, 1'b0),
            drow(CHAR_CR, 1'b1, 1'b0), drow(CHAR_LF, 1'b1, 1'b0),
            drow(8'h00, 1'b1, 1'b1), drow(8'hFF, 1'b1, 1'b1), drow(CHAR_CR, 1'b1, 1'b1),
            drow(CHAR_CR, 1'b1, 1'b0), drow("q", 1'b1, 1'b0),
            drow(CHAR_CR, 1'b1, 1'b0), drow(CHAR_LF, 1'b1, 1'b0),
            drow("0", 1'b1, 1'b0), drow("0", 1'b1, 1'b0), drow("2", 1'b1, 1'b0),
            drow(CHAR_CR, 1'b1, 1'b0), drow(CHAR_LF, 1'b1, 1'b0),
            drow(8'h80, 1'b1, 1'b1), drow(CHAR_LF, 1'b1, 1'b1),
            drow(CHAR_CR, 1'b0, 1'b0), drow(CHAR_LF, 1'b0, 1'b0)
        };
        foreach (dir_rows[i])
            push_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].want);
        settle();

        // Random chunks; at a random point in each, now and then switch to
        // length mode, move the limit, or pause until everything has drained.
        while (items_sent < RANDOM_ITEMS)
        begin
            build_chunk();
            split = $urandom_range(0, chunk_bytes.size());
            send_range(0, split);
            roll = $urandom_range(0, 19);
            if (roll == 0)
                length_mode_run();
            else if (roll == 1)
                move_limit();
            else if (roll == 2)
                settle();
            send_range(split, chunk_bytes.size());
        end

        close_body();

        // Drain with a bound, then allow a few cycles for stray results.
        in_valid <= 1'b0;
        spins = 0;
        while (expected_q.size() != 0 && spins < 20000)
        begin
            @(posedge clk);
            spins++;
        end
        repeat (8) @(posedge clk);
        if (expected_q.size() != 0)
        begin
            $display("%0t: %0d results never arrived, expected 0 left, actual %0d left",
                     $time, expected_q.size(), expected_q.size());
            mismatches++;
        end

        if (mismatches == 0)
            $display("http_chunked_body_decoder_top test passed");
        else
            $display("http_chunked_body_decoder_top test failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/hcbd_pkg.sv
sv/hcbd_step.sv
sv/hcbd_obuf.sv
sv/http_chunked_body_decoder_top.sv
sv/hcbd_checker.sv
test/tb_http_chunked_body_decoder_top.sv
